// File: hw/rtl/prwm_pkg.sv
// ----------------------------------------------------------------------------
// prwm_pkg
// Shared widths, register codes, reset values and types of the periodic
// random walk mean square displacement block.
// ----------------------------------------------------------------------------
package prwm_pkg;

  localparam int unsigned MAX_PARTICLES = 512;
  localparam int unsigned POSITION_BITS = 20;

  localparam int unsigned BOX_W      = 20;
  localparam int unsigned START_W    = 20;
  localparam int unsigned COUNT_W    = 10;
  localparam int unsigned SHIFT_W    = 16;
  localparam int unsigned SUM_W      = 50;
  localparam int unsigned MEAN_W     = 42;
  localparam int unsigned STEP_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd2;

  localparam logic [BOX_W-1:0]   BOX_RESET   = 20'd128000;
  localparam logic [START_W-1:0] START_RESET = 20'd64000;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 10'd500;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: hw/rtl/prwm_ram.sv
// ----------------------------------------------------------------------------
// prwm_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module prwm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/prwm_div.sv
// ----------------------------------------------------------------------------
// prwm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prwm_div #(
  parameter int unsigned NumW = 50,
  parameter int unsigned DenW = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NumW-1:0]       num_i,
  input  logic [DenW-1:0]       den_i,
  output prwm_pkg::div_status_t status_o,
  output logic [NumW-1:0]       quot_o
);
  import prwm_pkg::*;

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    diff   = trial - {1'b0, den_q};
    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      cnt_d  = CntW'(NumW);
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff;
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quot_o        = quo_q;

endmodule

// File: hw/rtl/periodic_random_walk_msd.sv
// ----------------------------------------------------------------------------
// periodic_random_walk_msd
// Mean square displacement of a 2-D random walk in a periodic box.
// Each word is read, wrapped and written back, squared and accumulated;
// the last word of a step adds a bit-serial divide and a hand-off, plus any
// wait for the previous result word. A new word is taken only when idle again.
// Reset loads register defaults and clears index, sum, step and fill count.
// ----------------------------------------------------------------------------
module periodic_random_walk_msd #(
  parameter int unsigned MaxParticles = prwm_pkg::MAX_PARTICLES,
  parameter int unsigned PositionBits = prwm_pkg::POSITION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // fields from bit 0: shift_x[15:0], shift_y[31:16]
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [prwm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // fields from bit 0: mean_square_disp[41:0], step_number[57:42], zero pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [prwm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prwm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [prwm_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import prwm_pkg::*;

  localparam int unsigned IdxW = (MaxParticles > 1) ? $clog2(MaxParticles) : 1;
  localparam int unsigned CntW = $clog2(MaxParticles + 1);
  localparam int unsigned PW   = PositionBits;
  localparam int unsigned DW   = (PW > START_W) ? PW : START_W;
  localparam int unsigned SW   = DW + 2;
  localparam int unsigned SqW  = 2 * DW;
  localparam int unsigned TW   = ((SqW > SUM_W) ? SqW : SUM_W) + 2;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_UPD  = 6'b000010,
    ST_SQR  = 6'b000100,
    ST_ACC  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  function automatic logic [PW-1:0] wrap_axis(input logic [PW-1:0]      pos,
                                              input logic [SHIFT_W-1:0] sh,
                                              input logic [BOX_W-1:0]   box);
    logic signed [SW-1:0] s;
    logic signed [SW-1:0] b;
    logic signed [SW-1:0] pmax;
    b    = $signed({{(SW-BOX_W){1'b0}}, box});
    pmax = $signed({{(SW-PW){1'b0}}, {PW{1'b1}}});
    s    = $signed({{(SW-PW){1'b0}}, pos}) + $signed({{(SW-SHIFT_W){sh[SHIFT_W-1]}}, sh});
    if (s > b) begin
      s = s - b;
    end else if (s < 0) begin
      s = s + b;
    end
    if (s < 0) begin
      s = '0;
    end
    if (s > b) begin
      s = b;
    end
    if (s > pmax) begin
      s = pmax;
    end
    return s[PW-1:0];
  endfunction

  state_e             state_q, state_d;
  logic [BOX_W-1:0]   box_q;
  logic [START_W-1:0] start_q;
  logic [COUNT_W-1:0] pcount_q;
  logic [IdxW-1:0]    index_q, index_d;
  logic [CntW-1:0]    fill_q, fill_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [STEP_W-1:0]  tag_q, tag_d;
  logic               out_valid_q, out_valid_d;
  logic [MEAN_W-1:0]  out_mean_q, out_mean_d;
  logic [STEP_W-1:0]  out_step_q, out_step_d;
  logic [SHIFT_W-1:0] shift_x_q, shift_x_d;
  logic [SHIFT_W-1:0] shift_y_q, shift_y_d;
  logic [PW-1:0]      pos_x_q, pos_x_d;
  logic [PW-1:0]      pos_y_q, pos_y_d;
  logic [SqW-1:0]     sq_x_q, sq_x_d;
  logic [SqW-1:0]     sq_y_q, sq_y_d;

  logic               in_acc;
  logic               ram_we;
  logic [2*PW-1:0]    ram_wdata;
  logic [2*PW-1:0]    ram_rdata;
  logic [PW-1:0]      seed;
  logic [PW-1:0]      old_x, old_y;
  logic [PW-1:0]      new_x, new_y;
  logic               entry_valid;
  logic [DW-1:0]      start_ext, px_ext, py_ext;
  logic [DW-1:0]      dist_x, dist_y;
  logic [TW-1:0]      total;
  logic [SUM_W-1:0]   sum_sat;
  logic [31:0]        count_wide;
  logic [CntW-1:0]    count_eff;
  logic               last_item;
  logic               div_start;
  div_status_t        div_status;
  logic [SUM_W-1:0]   div_quot;
  logic [MEAN_W-1:0]  mean_sat;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W-MEAN_W-STEP_W){1'b0}}, out_step_q, out_mean_q};

  prwm_ram #(
    .Width (2 * PW),
    .Depth (MaxParticles)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (index_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (index_q),
    .rdata_o (ram_rdata)
  );

  prwm_div #(
    .NumW (SUM_W),
    .DenW (CntW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (sum_sat),
    .den_i    (count_eff),
    .status_o (div_status),
    .quot_o   (div_quot)
  );

  always_comb begin
    if (32'(start_q) > 32'({PW{1'b1}})) begin
      seed = {PW{1'b1}};
    end else begin
      seed = PW'(start_q);
    end
    count_wide = 32'(pcount_q);
    if (count_wide == 32'd0) begin
      count_wide = 32'd1;
    end
    if (count_wide > 32'(MaxParticles)) begin
      count_wide = 32'(MaxParticles);
    end
    count_eff   = count_wide[CntW-1:0];
    last_item   = (32'(index_q) + 32'd1) >= count_wide;
    entry_valid = 32'(index_q) < 32'(fill_q);
    old_x       = entry_valid ? ram_rdata[PW-1:0] : seed;
    old_y       = entry_valid ? ram_rdata[2*PW-1:PW] : seed;
    new_x       = wrap_axis(old_x, shift_x_q, box_q);
    new_y       = wrap_axis(old_y, shift_y_q, box_q);
    ram_wdata   = {new_y, new_x};
    start_ext   = DW'(start_q);
    px_ext      = DW'(pos_x_q);
    py_ext      = DW'(pos_y_q);
    dist_x      = (start_ext > px_ext) ? start_ext - px_ext : px_ext - start_ext;
    dist_y      = (start_ext > py_ext) ? start_ext - py_ext : py_ext - start_ext;
    total       = TW'(sum_q) + TW'(sq_x_q) + TW'(sq_y_q);
    sum_sat     = (total > TW'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : total[SUM_W-1:0];
    mean_sat    = (|div_quot[SUM_W-1:MEAN_W]) ? {MEAN_W{1'b1}} : div_quot[MEAN_W-1:0];
  end

  always_comb begin
    state_d     = state_q;
    index_d     = index_q;
    fill_d      = fill_q;
    sum_d       = sum_q;
    step_d      = step_q;
    tag_d       = tag_q;
    out_valid_d = out_valid_q;
    out_mean_d  = out_mean_q;
    out_step_d  = out_step_q;
    shift_x_d   = shift_x_q;
    shift_y_d   = shift_y_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    sq_x_d      = sq_x_q;
    sq_y_d      = sq_y_q;
    ram_we      = 1'b0;
    div_start   = 1'b0;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          shift_x_d = s_axis_tdata[SHIFT_W-1:0];
          shift_y_d = s_axis_tdata[2*SHIFT_W-1:SHIFT_W];
          state_d   = ST_UPD;
        end
      end
      ST_UPD: begin
        ram_we  = 1'b1;
        pos_x_d = new_x;
        pos_y_d = new_y;
        if (32'(index_q) == 32'(fill_q)) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = ST_SQR;
      end
      ST_SQR: begin
        sq_x_d  = SqW'(dist_x) * SqW'(dist_x);
        sq_y_d  = SqW'(dist_y) * SqW'(dist_y);
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (last_item) begin
          div_start = 1'b1;
          tag_d     = step_q;
          step_d    = step_q + 1'b1;
          sum_d     = '0;
          index_d   = '0;
          state_d   = ST_DIV;
        end else begin
          sum_d   = sum_sat;
          index_d = index_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_mean_d  = mean_sat;
          out_step_d  = tag_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      box_q       <= BOX_RESET;
      start_q     <= START_RESET;
      pcount_q    <= COUNT_RESET;
      index_q     <= '0;
      fill_q      <= '0;
      sum_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      index_q     <= index_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BOX_LIMIT:      box_q    <= cfg_data_i[BOX_W-1:0];
          CFG_START_POSITION: start_q  <= cfg_data_i[START_W-1:0];
          CFG_PARTICLE_COUNT: pcount_q <= cfg_data_i[COUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q      <= tag_d;
    out_mean_q <= out_mean_d;
    out_step_q <= out_step_d;
    shift_x_q  <= shift_x_d;
    shift_y_q  <= shift_y_d;
    pos_x_q    <= pos_x_d;
    pos_y_q    <= pos_y_d;
    sq_x_q     <= sq_x_d;
    sq_y_q     <= sq_y_d;
  end

endmodule

// File: sim/tb_periodic_random_walk_msd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_random_walk_msd
// Self-checking bench for the periodic random walk MSD block. A scoreboard
// class tracks particle positions, the running square sum and the step
// counter, and predicts the mean square displacement word of every completed
// step. Directed words hit the field extremes, clamping in tiny boxes, the
// zero particle count, a count lowered mid-step and a long output hold-off.
// Random phases then retune the registers between bursts, with random stalls
// on both streams and occasional over-range counts.
// ----------------------------------------------------------------------------
module tb_periodic_random_walk_msd;
  import prwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned RANDOM_WORDS  = 500;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint unsigned POS_MAX  = (64'd1 << POSITION_BITS) - 1;
  localparam longint unsigned SUM_MAX  = (64'd1 << SUM_W) - 1;
  localparam longint unsigned MEAN_MAX = (64'd1 << MEAN_W) - 1;

  typedef struct packed {
    logic [MEAN_W-1:0] msd;
    logic [STEP_W-1:0] step_no;
  } msd_word_t;

  class msd_book;
    logic [BOX_W-1:0]         box;
    logic [START_W-1:0]       start;
    logic [COUNT_W-1:0]       count;
    logic [POSITION_BITS-1:0] pos_x [MAX_PARTICLES];
    logic [POSITION_BITS-1:0] pos_y [MAX_PARTICLES];
    bit                       moved [MAX_PARTICLES];
    int unsigned              idx;
    longint unsigned          sum;
    logic [STEP_W-1:0]        step_count;
    msd_word_t                due [$];
    int unsigned              errors, words, steps, writes;

    function new();
      box        = BOX_RESET;
      start      = START_RESET;
      count      = COUNT_RESET;
      foreach (moved[i]) moved[i] = 1'b0;
      idx        = 0;
      sum        = 0;
      step_count = '0;
      errors     = 0;
      words      = 0;
      steps      = 0;
      writes     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      writes++;
      case (index)
        CFG_BOX_LIMIT:      box   = value[BOX_W-1:0];
        CFG_START_POSITION: start = value[START_W-1:0];
        CFG_PARTICLE_COUNT: count = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_count();
      if (count == 0) return 1;
      if (count > MAX_PARTICLES) return MAX_PARTICLES;
      return count;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function logic [POSITION_BITS-1:0] wrap(logic [POSITION_BITS-1:0] pos,
                                            logic [SHIFT_W-1:0] shift);
      longint b, s;
      b = longint'(box);
      s = longint'(pos) + longint'($signed(shift));
      if (s > b) s -= b;
      else if (s < 0) s += b;
      if (s < 0) s = 0;
      if (s > b) s = b;
      if (s > longint'(POS_MAX)) s = longint'(POS_MAX);
      return s[POSITION_BITS-1:0];
    endfunction

    function void add_square(logic [POSITION_BITS-1:0] p);
      longint unsigned a, c, d;
      a = start;
      c = p;
      d = (a > c) ? a - c : c - a;
      sum = sum + d * d;
      if (sum > SUM_MAX) sum = SUM_MAX;
    endfunction

    function void note_word(logic [SHIFT_W-1:0] sx, logic [SHIFT_W-1:0] sy);
      int unsigned              cnt, k;
      logic [POSITION_BITS-1:0] px, py;
      longint unsigned          mean;
      cnt = eff_count();
      k   = (idx >= MAX_PARTICLES) ? MAX_PARTICLES - 1 : idx;
      if (moved[k]) begin
        px = pos_x[k];
        py = pos_y[k];
      end else begin
        px = (longint'(start) > longint'(POS_MAX)) ? POS_MAX[POSITION_BITS-1:0] : start;
        py = px;
      end
      px = wrap(px, sx);
      py = wrap(py, sy);
      pos_x[k] = px;
      pos_y[k] = py;
      moved[k] = 1'b1;
      add_square(px);
      add_square(py);
      words++;
      if (k + 1 >= cnt) begin
        mean = sum / cnt;
        if (mean > MEAN_MAX) mean = MEAN_MAX;
        due.push_back('{msd: mean[MEAN_W-1:0], step_no: step_count});
        sum = 0;
        idx = 0;
        step_count++;
      end else begin
        idx = k + 1;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data);
      msd_word_t exp_w;
      if (due.size() == 0) begin
        $error("unexpected result word: mean_square_disp %0d, step_number %0d",
               data[MEAN_W-1:0], data[MEAN_W+STEP_W-1:MEAN_W]);
        errors++;
        return;
      end
      exp_w = due.pop_front();
      steps++;
      if (data[MEAN_W-1:0] !== exp_w.msd) begin
        $error("mean_square_disp: expected %0d, got %0d", exp_w.msd, data[MEAN_W-1:0]);
        errors++;
      end
      if (data[MEAN_W+STEP_W-1:MEAN_W] !== exp_w.step_no) begin
        $error("step_number: expected %0d, got %0d", exp_w.step_no,
               data[MEAN_W+STEP_W-1:MEAN_W]);
        errors++;
      end
      if (data[OUT_DATA_W-1:MEAN_W+STEP_W] !== '0) begin
        $error("pad: expected 0, got %0h", data[OUT_DATA_W-1:MEAN_W+STEP_W]);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int unsigned hold_cycles;
  msd_book     book = new();

  periodic_random_walk_msd u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SHIFT_W-1:0] rand_shift();
    if ($urandom_range(0, 1) == 1) return SHIFT_W'($urandom);
    return SHIFT_W'($urandom_range(0, 1024) - 512);
  endfunction

  task automatic send_word(input logic [SHIFT_W-1:0] sx, input logic [SHIFT_W-1:0] sy,
                           input int unsigned gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    book.note_word(sx, sy);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    book.set_reg(index, value);
  endtask

  task automatic configure(input bit [2:0] pick, input logic [BOX_W-1:0] box_v,
                           input logic [START_W-1:0] start_v,
                           input logic [COUNT_W-1:0] count_v);
    if (pick[0]) write_reg(CFG_BOX_LIMIT, box_v);
    if (pick[1]) write_reg(CFG_START_POSITION, start_v);
    if (pick[2]) write_reg(CFG_PARTICLE_COUNT, CFG_DATA_W'(count_v));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : sink
    int unsigned stall;
    bit          eager;
    stall = 0;
    eager = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) book.check_result(m_axis_tdata);
      if ($urandom_range(0, 299) == 0) eager = !eager;
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (!eager) stall = pick_gap();
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_periodic_random_walk_msd NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned          n, goal, eff, r;
    bit [2:0]             pick;
    bit                   eager;
    logic [BOX_W-1:0]     box_v;
    logic [START_W-1:0]   start_v;
    logic [COUNT_W-1:0]   count_v;
    hold_cycles = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_BOX_LIMIT;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tiny box: full-scale shifts clamp to the edges
    configure(3'b111, 20'd1000, 20'd500, 10'd3);
    send_word(16'h7fff, 16'h8000, 0);
    send_word(16'h8000, 16'h7fff, 0);
    send_word(16'h0000, 16'h0000, 0);
    settle();

    // zero count acts as one particle
    configure(3'b111, 20'd1, 20'd0, 10'd0);
    send_word(16'h7fff, 16'h8000, 1);
    send_word(16'hffff, 16'h0001, 0);
    settle();

    configure(3'b111, 20'hfffff, 20'hfffff, 10'd4);
    send_word(16'h7fff, 16'h7fff, 0);
    send_word(16'h8000, 16'h8000, 0);
    send_word(16'h0064, 16'hff9c, 2);
    send_word(16'hffff, 16'h0001, 0);
    settle();

    // lower the count below the particle index mid-step
    write_reg(CFG_UNUSED, 20'h5a5a5);
    configure(3'b101, 20'd200000, 20'd0, 10'd8);
    repeat (5) send_word(rand_shift(), rand_shift(), 0);
    settle();
    configure(3'b100, 20'd0, 20'd0, 10'd3);
    send_word(16'h0100, 16'hff00, 0);
    settle();

    // hold the output off so the block backs up
    configure(3'b111, 20'd300000, 20'd150000, 10'd1);
    hold_cycles = 400;
    repeat (30) send_word(rand_shift(), rand_shift(), 0);
    settle();

    goal = book.words + RANDOM_WORDS;
    while (book.words < goal) begin
      pick = 3'($urandom_range(1, 7));
      r = $urandom_range(0, 99);
      if (r < 5) box_v = 20'd1;
      else if (r < 10) box_v = 20'hfffff;
      else if (r < 75) box_v = 20'($urandom_range(65536, 1048575));
      else box_v = 20'($urandom_range(1, 65535));
      if ($urandom_range(0, 9) < 7) start_v = 20'($urandom_range(0, box_v));
      else start_v = 20'($urandom);
      r = $urandom_range(0, 99);
      if (r < 80) count_v = 10'($urandom_range(1, 12));
      else if (r < 88) count_v = 10'd0;
      else if (r < 96) count_v = 10'($urandom_range(13, 60));
      else count_v = 10'($urandom_range(513, 1023));
      configure(pick, box_v, start_v, count_v);
      eff   = book.eff_count();
      n     = $urandom_range(1, (eff > 40) ? 120 : 3 * eff + 4);
      eager = ($urandom_range(0, 3) == 0);
      repeat (n) send_word(rand_shift(), rand_shift(), eager ? 0 : pick_gap());
      settle();
    end

    repeat (60) @(posedge clk_i);
    if (book.pending() != 0) begin
      $error("%0d result words never arrived", book.pending());
      book.errors++;
    end
    $display("%0d words driven, %0d steps checked, %0d register writes",
             book.words, book.steps, book.writes);
    if (book.errors == 0) begin
      $display("tb_periodic_random_walk_msd OK");
    end else begin
      $display("tb_periodic_random_walk_msd NOT OK");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/prwm_pkg.sv
hw/rtl/prwm_ram.sv
hw/rtl/prwm_div.sv
hw/rtl/periodic_random_walk_msd.sv
sim/tb_periodic_random_walk_msd.sv
